/* hdl/pfr_pkg.sv */
// shared types, sizes and codes for the packet fragment reassembly block
// used by pfr_front, pfr_queue, pfr_back and packet_fragment_reassembly
`default_nettype none

package pfr_pkg;

	// table geometry (both powers of two)
	localparam int NUM_SLOTS   = 16;
	localparam int SLOT_BYTES  = 2048;
	localparam int SLOT_W      = $clog2(NUM_SLOTS);
	localparam int OFF_W       = $clog2(SLOT_BYTES);
	localparam int ADDR_W      = SLOT_W + OFF_W;
	localparam int STORE_DEPTH = NUM_SLOTS * SLOT_BYTES;
	localparam int LEN_W       = $clog2(SLOT_BYTES + 1);
	localparam int CNT_MAX     = 255;

	// fixed port field widths
	localparam int SLOT_FIELD_W = 4;
	localparam int LEN_FIELD_W  = 12;

	// item kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_STORED   = 2'd0,
		ST_DROPPED  = 2'd1,
		ST_COMPLETE = 2'd2,
		ST_READ     = 2'd3
	} status_t;

	// classified item handed from front to back
	typedef struct packed {
		logic              kind;
		logic [31:0]       seq;
		logic [7:0]        total;
		logic [SLOT_W-1:0] slot;
		logic [OFF_W-1:0]  offset;
		logic [7:0]        data;
		logic              fend;
	} item_t;

	// handshake between two parts
	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

	// slot number to the 4-bit port field
	function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
		logic [31:0] wide;
		wide = 32'(s);
		return wide[SLOT_FIELD_W-1:0];
	endfunction

	// slot length to the 12-bit port field
	function automatic logic [LEN_FIELD_W-1:0] len_field(input logic [LEN_W-1:0] l);
		logic [31:0] wide;
		wide = 32'(l);
		return wide[LEN_FIELD_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* hdl/packet_fragment_reassembly.sv */
// Packet fragment reassembly: top level with front, queue and back parts.
// Depends on pfr_pkg, pfr_front, pfr_queue and pfr_back.
//
// Input channel (in_valid/in_ready) carries one item per handshake: a
// fragment data byte (kind 0) or a read of a stored byte (kind 1). Output
// channel (out_valid/out_ready) returns exactly one result item per input
// item, in order. Items pass through a two-entry queue into the back part,
// which updates the 16-entry slot table and the 32 KiB packet store for each
// item it takes (single-port store, read data registered). An accepted item
// is held in a queue entry, then registered in the result register.
// Throughput: one item per cycle while out_ready stays high.
// Reset clears the slot table (all slots free) and empties the queue; the
// packet store is not cleared and needs no clearing pass, so items are taken
// from the first cycle after reset.
// When the receiver stalls, the result register holds, the back part stops
// taking items, and the queue absorbs up to two more items before in_ready
// falls.
`default_nettype none

module packet_fragment_reassembly (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic         kind,
	input  wire logic [31:0]  seq_num,
	input  wire logic [7:0]   frag_total,
	input  wire logic [10:0]  byte_offset,
	input  wire logic [7:0]   data_byte,
	input  wire logic         frag_end,
	input  wire logic [3:0]   read_slot,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [1:0]        status,
	output logic [3:0]        slot_index,
	output logic [11:0]       packet_length,
	output logic [7:0]        read_byte
);

	pfr_pkg::item_t front_item;
	pfr_pkg::item_t back_item;
	pfr_pkg::hs_t   back_hs;

	// classify
	pfr_front u_front (
		.kind        (kind),
		.seq_num     (seq_num),
		.frag_total  (frag_total),
		.byte_offset (byte_offset),
		.data_byte   (data_byte),
		.frag_end    (frag_end),
		.read_slot   (read_slot),
		.item        (front_item)
	);

	// decoupling queue
	pfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_item  (front_item),
		.pop_valid  (back_hs.valid),
		.pop_ready  (back_hs.ready),
		.pop_item   (back_item)
	);

	// execute
	pfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (back_hs.valid),
		.item_ready    (back_hs.ready),
		.item          (back_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.slot_index    (slot_index),
		.packet_length (packet_length),
		.read_byte     (read_byte)
	);

	// a stalled result blocks the back part
	a_stall_blocks_back: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !back_hs.ready)
		else $error("back part took an item while the result was stalled");

	// a dropped byte reports no length
	a_drop_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == pfr_pkg::ST_DROPPED) |-> (packet_length == 12'd0))
		else $error("dropped item reports a nonzero length");

	// only reads carry a data byte
	a_byte_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != pfr_pkg::ST_READ) |-> (read_byte == 8'd0))
		else $error("non-read result carries a data byte");

	// a taken item from the queue yields a result next cycle
	a_take_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(back_hs.valid && back_hs.ready) |=> out_valid)
		else $error("item taken by the back part gave no result");

endmodule

`default_nettype wire

/* hdl/pfr_front.sv */
// front part: classifies an incoming item and picks its slot and offset
// depends on pfr_pkg
`default_nettype none

module pfr_front (
	input  wire logic                kind,
	input  wire logic [31:0]         seq_num,
	input  wire logic [7:0]          frag_total,
	input  wire logic [10:0]         byte_offset,
	input  wire logic [7:0]          data_byte,
	input  wire logic                frag_end,
	input  wire logic [3:0]          read_slot,
	output pfr_pkg::item_t           item
);

	logic [31:0] seq_slot;
	logic [31:0] rd_slot;
	logic [31:0] off_wrap;

	// slot and offset wrap by power-of-two table sizes
	assign seq_slot = seq_num % pfr_pkg::NUM_SLOTS;
	assign rd_slot  = 32'(read_slot) % pfr_pkg::NUM_SLOTS;
	assign off_wrap = 32'(byte_offset) % pfr_pkg::SLOT_BYTES;

	// build the classified item
	always_comb begin
		item.kind   = kind;
		item.seq    = seq_num;
		item.total  = frag_total;
		item.slot   = (kind == pfr_pkg::KIND_READ) ? rd_slot[pfr_pkg::SLOT_W-1:0]
			: seq_slot[pfr_pkg::SLOT_W-1:0];
		item.offset = off_wrap[pfr_pkg::OFF_W-1:0];
		item.data   = data_byte;
		item.fend   = frag_end;
	end

endmodule

`default_nettype wire

/* hdl/pfr_queue.sv */
// two-entry item queue between front and back
// depends on pfr_pkg
`default_nettype none

module pfr_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire pfr_pkg::item_t  push_item,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output pfr_pkg::item_t       pop_item
);

	pfr_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

`default_nettype wire

/* hdl/pfr_back.sv */
// back part: slot table update, packet store and result register
// depends on pfr_pkg
`default_nettype none

module pfr_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	input  wire pfr_pkg::item_t  item,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [1:0]           status,
	output logic [3:0]           slot_index,
	output logic [11:0]          packet_length,
	output logic [7:0]           read_byte
);

	// slot table
	logic                    slot_valid_q [pfr_pkg::NUM_SLOTS];
	logic [31:0]             slot_seq_q   [pfr_pkg::NUM_SLOTS];
	logic [pfr_pkg::LEN_W-1:0] slot_len_q [pfr_pkg::NUM_SLOTS];
	logic [7:0]              slot_cnt_q   [pfr_pkg::NUM_SLOTS];

	// packet store
	logic [7:0]                  store_q [pfr_pkg::STORE_DEPTH];
	logic [7:0]                  rd_data_q;
	logic [pfr_pkg::ADDR_W-1:0]  addr;

	// result register
	logic                        out_valid_q;
	pfr_pkg::status_t            status_q;
	logic [pfr_pkg::SLOT_W-1:0]  slot_q;
	logic [pfr_pkg::LEN_W-1:0]   len_q;

	logic                        take;
	logic                        cur_valid;
	logic                        busy;
	logic [pfr_pkg::LEN_W-1:0]   base_len;
	logic [7:0]                  base_cnt;
	logic [pfr_pkg::LEN_W-1:0]   new_len;
	logic [7:0]                  new_cnt;
	logic                        complete;
	logic                        do_write;

	assign item_ready = !out_valid_q || out_ready;
	assign take       = item_valid && item_ready;
	assign addr       = {item.slot, item.offset};

	// slot lookup and next-state values
	always_comb begin
		cur_valid = slot_valid_q[item.slot];
		busy      = cur_valid && (slot_seq_q[item.slot] != item.seq);
		base_len  = cur_valid ? slot_len_q[item.slot] : '0;
		base_cnt  = cur_valid ? slot_cnt_q[item.slot] : 8'd0;
		new_len   = (32'(base_len) < pfr_pkg::SLOT_BYTES) ? base_len + 1'b1 : base_len;
		new_cnt   = base_cnt;
		if (item.fend && (32'(base_cnt) < pfr_pkg::CNT_MAX))
			new_cnt = base_cnt + 8'd1;
		complete  = item.fend && (new_cnt >= item.total);
		do_write  = take && (item.kind == pfr_pkg::KIND_DATA) && !busy;
	end

	// slot table update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pfr_pkg::NUM_SLOTS; i++) begin
				slot_valid_q[i] <= 1'b0;
				slot_seq_q[i]   <= 32'd0;
				slot_len_q[i]   <= '0;
				slot_cnt_q[i]   <= 8'd0;
			end
		end else if (do_write) begin
			if (complete) begin
				slot_valid_q[item.slot] <= 1'b0;
				slot_seq_q[item.slot]   <= 32'd0;
				slot_len_q[item.slot]   <= '0;
				slot_cnt_q[item.slot]   <= 8'd0;
			end else begin
				slot_valid_q[item.slot] <= 1'b1;
				slot_seq_q[item.slot]   <= item.seq;
				slot_len_q[item.slot]   <= new_len;
				slot_cnt_q[item.slot]   <= new_cnt;
			end
		end
	end

	// store write and registered read
	always_ff @(posedge clk) begin
		if (do_write)
			store_q[addr] <= item.data;
		else if (take && (item.kind == pfr_pkg::KIND_READ))
			rd_data_q <= store_q[addr];
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			slot_q <= item.slot;
			if (item.kind == pfr_pkg::KIND_READ) begin
				status_q <= pfr_pkg::ST_READ;
				len_q    <= slot_len_q[item.slot];
			end else if (busy) begin
				status_q <= pfr_pkg::ST_DROPPED;
				len_q    <= '0;
			end else begin
				status_q <= complete ? pfr_pkg::ST_COMPLETE : pfr_pkg::ST_STORED;
				len_q    <= new_len;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot_index    = pfr_pkg::slot_field(slot_q);
	assign packet_length = pfr_pkg::len_field(len_q);
	assign read_byte     = (status_q == pfr_pkg::ST_READ) ? rd_data_q : 8'd0;

endmodule

`default_nettype wire
